FILE: rtl/assert_macros.svh
// assertion macros used by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define TRBA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define TRBA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `TRBA_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/trba_pkg.sv
// shared constants, types and command/status structs of the tile allocator
`default_nettype none

package trba_pkg;

  localparam int NUM_TILES  = 1024;
  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = NUM_TILES / WORD_W;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int HI_W       = BIT_W + 1;
  localparam int GROUP_W    = 8;
  localparam int NUM_GROUPS = WORD_W / GROUP_W;
  localparam int GSEL_W     = $clog2(NUM_GROUPS);
  localparam int GBIT_W     = $clog2(GROUP_W);
  localparam int TILE_W     = $clog2(NUM_TILES);
  localparam int MODE_W     = 2;
  localparam int LEN_W      = 11;
  localparam int IDX_W      = 10;

  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MARK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_UPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic find_step;
    logic upd_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_find;
    logic in_update;
    logic in_range_ok;
    logic scan_hit;
    logic group_last;
    logic word_last;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/trba_ctrl.sv
// request sequencer of the tile allocator
`default_nettype none

module trba_ctrl import trba_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  dp_status_t  status_i,
  output ctrl_cmd_t   cmd_o,
  output logic        in_stall_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.in_find) begin
            state_d = ST_FIND;
          end else if (status_i.in_update && status_i.in_range_ok) begin
            state_d = ST_UPD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_FIND: begin
        if (status_i.scan_hit || (status_i.group_last && status_i.word_last)) begin
          state_d = ST_DONE;
        end
      end
      ST_UPD: begin
        if (status_i.word_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_FIND: cmd_o.find_step = 1'b1;
      ST_UPD:  cmd_o.upd_step  = 1'b1;
      ST_DONE: cmd_o.out_load  = !status_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/trba_dp.sv
// bitmap memory, run scanner, range updater and result register
`default_nettype none

module trba_dp import trba_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  input  wire [MODE_W-1:0]   mode_i,
  input  wire [LEN_W-1:0]    run_length_i,
  input  wire [IDX_W-1:0]    start_tile_i,
  input  wire [LEN_W-1:0]    end_tile_i,
  input  wire                out_stall_i,
  output logic               out_valid_o,
  output logic [IDX_W-1:0]   tile_index_o,
  output logic               found_o
);

  logic [WORD_W-1:0]  mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_vld_q;
  logic [WORD_W-1:0]  rd_data_q;
  logic               rd_vld_q;

  logic [MODE_W-1:0]  mode_q;
  logic [LEN_W-1:0]   len_q;
  logic [IDX_W-1:0]   start_q;
  logic [IDX_W-1:0]   endm1_q;
  logic [WADDR_W-1:0] word_q, word_d;
  logic [GSEL_W-1:0]  group_q, group_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   res_idx_q, res_idx_d;
  logic               res_found_q, res_found_d;
  logic               out_valid_q, out_valid_d;
  logic [IDX_W-1:0]   out_idx_q;
  logic               out_found_q;

  logic [LEN_W-1:0]   endc_in;
  logic               in_update;
  logic               range_ok;
  logic [WORD_W-1:0]  rd_word;
  logic [WADDR_W-1:0] end_word;
  logic               word_last;

  logic [LEN_W-1:0]   cnt_v;
  logic               hit_v;
  logic [GBIT_W-1:0]  hit_bit_v;
  logic [TILE_W-1:0]  hit_tile;
  logic [LEN_W-1:0]   hit_start;

  logic [BIT_W-1:0]   lo_v;
  logic [HI_W-1:0]    hi_v;
  logic [WORD_W-1:0]  mask_v;
  logic [WORD_W-1:0]  wr_word;

  assign endc_in   = (end_tile_i > LEN_W'(NUM_TILES)) ? LEN_W'(NUM_TILES) : end_tile_i;
  assign in_update = (mode_i == MODE_MARK) || (mode_i == MODE_CLEAR);
  assign range_ok  = {1'b0, start_tile_i} < endc_in;

  assign rd_word   = rd_vld_q ? rd_data_q : '0;
  assign end_word  = endm1_q[TILE_W-1:BIT_W];
  assign word_last = (mode_q == MODE_FIND) ? (word_q == WADDR_W'(NUM_WORDS - 1))
                                           : (word_q == end_word);

  // run count over one group of bits, first hit wins
  always_comb begin
    cnt_v     = cnt_q;
    hit_v     = 1'b0;
    hit_bit_v = '0;
    for (int k = 0; k < GROUP_W; k++) begin
      if (!hit_v) begin
        if (rd_word[{group_q, GBIT_W'(k)}]) begin
          cnt_v = '0;
        end else begin
          cnt_v = cnt_v + LEN_W'(1);
          if (cnt_v == len_q) begin
            hit_v     = 1'b1;
            hit_bit_v = GBIT_W'(k);
          end
        end
      end
    end
  end

  assign hit_tile  = {word_q, group_q, hit_bit_v};
  assign hit_start = LEN_W'(hit_tile) + LEN_W'(1) - len_q;

  // bit mask of the range inside the current word
  always_comb begin
    lo_v = (word_q == start_q[TILE_W-1:BIT_W]) ? start_q[BIT_W-1:0] : '0;
    hi_v = (word_q == end_word) ? ({1'b0, endm1_q[BIT_W-1:0]} + HI_W'(1))
                                : HI_W'(WORD_W);
    for (int b = 0; b < WORD_W; b++) begin
      mask_v[b] = (BIT_W'(b) >= lo_v) && (HI_W'(b) < hi_v);
    end
  end

  assign wr_word = (mode_q == MODE_MARK) ? (rd_word | mask_v) : (rd_word & ~mask_v);

  always_comb begin
    word_d      = word_q;
    group_d     = group_q;
    cnt_d       = cnt_q;
    res_idx_d   = res_idx_q;
    res_found_d = res_found_q;
    if (cmd_i.load) begin
      word_d      = (mode_i == MODE_FIND) ? '0 : start_tile_i[TILE_W-1:BIT_W];
      group_d     = '0;
      cnt_d       = '0;
      res_idx_d   = in_update ? start_tile_i : '0;
      res_found_d = in_update && range_ok;
    end else if (cmd_i.find_step) begin
      group_d = group_q + GSEL_W'(1);
      cnt_d   = cnt_v;
      if (hit_v) begin
        res_idx_d   = IDX_W'(hit_start);
        res_found_d = 1'b1;
      end else if ((group_q == GSEL_W'(NUM_GROUPS - 1)) && !word_last) begin
        word_d = word_q + WADDR_W'(1);
      end
    end else if (cmd_i.upd_step && !word_last) begin
      word_d = word_q + WADDR_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // bitmap words, read address follows the next word
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_step) begin
      mem_q[word_q] <= wr_word;
    end
    rd_data_q <= mem_q[word_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (cmd_i.upd_step) begin
      row_vld_q[word_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q <= row_vld_q[word_d];
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      len_q   <= run_length_i;
      start_q <= start_tile_i;
      endm1_q <= IDX_W'(endc_in - LEN_W'(1));
    end
    word_q      <= word_d;
    group_q     <= group_d;
    cnt_q       <= cnt_d;
    res_idx_q   <= res_idx_d;
    res_found_q <= res_found_d;
    if (cmd_i.out_load) begin
      out_idx_q   <= res_idx_q;
      out_found_q <= res_found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.in_find     = (mode_i == MODE_FIND);
  assign status_o.in_update   = in_update;
  assign status_o.in_range_ok = range_ok;
  assign status_o.scan_hit    = hit_v;
  assign status_o.group_last  = (group_q == GSEL_W'(NUM_GROUPS - 1));
  assign status_o.word_last   = word_last;
  assign status_o.out_busy    = out_valid_q && out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign tile_index_o = out_idx_q;
  assign found_o      = out_found_q;

endmodule

`default_nettype wire

FILE: rtl/tile_run_bitmap_allocator.sv
// top level of the first-fit tile run allocator
// find: accept, then scan each 32-tile bitmap word in 8-tile groups (8 tiles a cycle), then the result;
//   the scan stops early when the run is found
// mark/clear: accept, then a read-modify-write of each word touched in turn, then the result
// one request at a time; a new request is taken while the last result still waits
// reset marks every tile free at once through per-word valid flags, no clearing pass
`default_nettype none
`include "assert_macros.svh"

module tile_run_bitmap_allocator import trba_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire [MODE_W-1:0]   mode_i,
  input  wire [LEN_W-1:0]    run_length_i,
  input  wire [IDX_W-1:0]    start_tile_i,
  input  wire [LEN_W-1:0]    end_tile_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [IDX_W-1:0]   tile_index_o,
  output logic               found_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  trba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  trba_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .mode_i       (mode_i),
    .run_length_i (run_length_i),
    .start_tile_i (start_tile_i),
    .end_tile_i   (end_tile_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .tile_index_o (tile_index_o),
    .found_o      (found_o)
  );

  `TRBA_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "not busy after input transfer")
  `TRBA_ASSERT_NEVER(a_no_result_overwrite, clk_i, rst_ni, cmd.out_load && out_valid_o && out_stall_i, "result overwritten while stalled")
  `TRBA_ASSERT(a_valid_drops, clk_i, rst_ni, (out_valid_o && !out_stall_i && !cmd.out_load) |=> !out_valid_o, "result repeated after transfer")

endmodule

`default_nettype wire
